// File: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the framed packet receiver: parse phases,
// result layout, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // Frame start bytes
    localparam logic [7:0] START_BYTE_0 = 8'h02;
    localparam logic [7:0] START_BYTE_1 = 8'hFD;

    // Configuration reset values
    localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] MAX_LEN_RESET     = 16'd64;

    // Configuration register indexes
    localparam logic CFG_GAP_TIMEOUT = 1'b0;
    localparam logic CFG_MAX_LEN     = 1'b1;

    // Input beat function codes
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Frame end status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
    localparam logic [1:0] STATUS_LEN_ERR  = 2'd2;

    typedef enum logic [3:0] {
        PH_STX0  = 4'd0,
        PH_STX1  = 4'd1,
        PH_TYPE  = 4'd2,
        PH_CMD_L = 4'd3,
        PH_CMD_H = 4'd4,
        PH_ERR_L = 4'd5,
        PH_ERR_H = 4'd6,
        PH_LEN_L = 4'd7,
        PH_LEN_H = 4'd8,
        PH_DATA  = 4'd9,
        PH_CSUM  = 4'd10
    } t_phase;

    typedef struct packed {
        logic [15:0] gap_timeout_ms;
        logic [15:0] max_payload_len;
    } t_cfg;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_type;
        logic [15:0] command;
        logic [15:0] error_field;
        logic [15:0] payload_length;
        logic [1:0]  status;
    } t_result;

endpackage

// File: rtl/fpr_parser.sv
// ----------------------------------------------------------------------------
// fpr_parser
// Per-beat frame parser: holds the parse phase, header fields, checksum and
// idle counter, and forms at most one result for each accepted beat.
// ----------------------------------------------------------------------------
module fpr_parser
    import fpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    input  t_cfg        i_cfg,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_cmd, n_cmd;
    logic [15:0] r_err, n_err;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] r_idle, n_idle;

    t_phase      phase_eff;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic [7:0]  csum_want;

    assign phase_eff = (r_idle >= i_cfg.gap_timeout_ms) ? PH_STX0 : r_phase;
    assign len_full  = {i_rx_byte, r_len[7:0]};
    assign count_inc = r_count + 16'd1;
    assign csum_want = 8'd0 - r_sum;

    // Next state and result for one beat
    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_type      = r_type;
        n_cmd       = r_cmd;
        n_err       = r_err;
        n_len       = r_len;
        n_count     = r_count;
        n_idle      = r_idle;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (i_func == FUNC_TICK) begin
                // saturate the idle counter
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 16'd1;
                end
            end else begin
                n_idle  = '0;
                n_phase = phase_eff;
                case (phase_eff)
                    PH_STX1: begin
                        if (i_rx_byte == START_BYTE_1) begin
                            n_sum   = r_sum + i_rx_byte;
                            n_phase = PH_TYPE;
                        end else begin
                            n_phase = PH_STX0;
                        end
                    end
                    PH_TYPE: begin
                        n_type  = i_rx_byte;
                        n_sum   = r_sum + i_rx_byte;
                        n_phase = PH_CMD_L;
                    end
                    PH_CMD_L: begin
                        n_cmd   = {8'd0, i_rx_byte};
                        n_sum   = r_sum + i_rx_byte;
                        n_phase = PH_CMD_H;
                    end
                    PH_CMD_H: begin
                        n_cmd   = {i_rx_byte, r_cmd[7:0]};
                        n_sum   = r_sum + i_rx_byte;
                        n_phase = PH_ERR_L;
                    end
                    PH_ERR_L: begin
                        n_err   = {8'd0, i_rx_byte};
                        n_sum   = r_sum + i_rx_byte;
                        n_phase = PH_ERR_H;
                    end
                    PH_ERR_H: begin
                        n_err   = {i_rx_byte, r_err[7:0]};
                        n_sum   = r_sum + i_rx_byte;
                        n_phase = PH_LEN_L;
                    end
                    PH_LEN_L: begin
                        n_len   = {8'd0, i_rx_byte};
                        n_sum   = r_sum + i_rx_byte;
                        n_phase = PH_LEN_H;
                    end
                    PH_LEN_H: begin
                        n_len = len_full;
                        n_sum = r_sum + i_rx_byte;
                        if (len_full == 16'd0) begin
                            // no payload: next byte is the checksum
                            n_phase = PH_CSUM;
                        end else if (len_full > i_cfg.max_payload_len) begin
                            // drop the frame at once
                            n_phase              = PH_STX0;
                            o_res_valid          = 1'b1;
                            o_res.result_kind    = KIND_END;
                            o_res.frame_type     = r_type;
                            o_res.command        = r_cmd;
                            o_res.error_field    = r_err;
                            o_res.payload_length = len_full;
                            o_res.status         = STATUS_LEN_ERR;
                        end else begin
                            n_count = '0;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        o_res_valid         = 1'b1;
                        o_res.result_kind   = KIND_PAYLOAD;
                        o_res.payload_byte  = i_rx_byte;
                        o_res.payload_index = r_count;
                        n_sum   = r_sum + i_rx_byte;
                        n_count = count_inc;
                        if (count_inc == r_len) begin
                            n_phase = PH_CSUM;
                        end
                    end
                    PH_CSUM: begin
                        n_phase              = PH_STX0;
                        o_res_valid          = 1'b1;
                        o_res.result_kind    = KIND_END;
                        o_res.frame_type     = r_type;
                        o_res.command        = r_cmd;
                        o_res.error_field    = r_err;
                        o_res.payload_length = r_len;
                        o_res.status = (csum_want == i_rx_byte) ? STATUS_OK
                                                                : STATUS_CSUM_ERR;
                    end
                    default: begin
                        // first start-byte search
                        if (i_rx_byte == START_BYTE_0) begin
                            n_sum   = i_rx_byte;
                            n_phase = PH_STX1;
                        end else begin
                            n_phase = PH_STX0;
                        end
                    end
                endcase
            end
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STX0;
            r_sum   <= '0;
            r_type  <= '0;
            r_cmd   <= '0;
            r_err   <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_idle  <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_type  <= n_type;
            r_cmd   <= n_cmd;
            r_err   <= n_err;
            r_len   <= n_len;
            r_count <= n_count;
            r_idle  <= n_idle;
        end
    end

endmodule

// File: rtl/fpr_out_buf.sv
// ----------------------------------------------------------------------------
// fpr_out_buf
// Two-entry output buffer: a result register plus a skid register, so the
// upstream ready comes straight from a flop.
// ----------------------------------------------------------------------------
module fpr_out_buf
    import fpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // Move beats between main and skid entries
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (!r_main_valid || pop) begin
            n_main_valid = i_push;
            if (i_push) begin
                n_main = i_data;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload entries
    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// File: rtl/framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Byte-serial receiver for 0x02 0xFD framed packets with header, payload and
// two's-complement checksum; streams payload bytes and reports frame end.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | fields
//  in      | input     | i_in_valid / o_in_ready    | i_func, i_rx_byte
//  out     | output    | o_out_valid / i_out_ready  | o_result_kind .. o_status
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_addr, i_cfg_wdata
//
//  One beat per cycle while o_in_ready is high; results are registered.
//  Parser state and the output buffer set the rate: one parse step per beat.
//  Synchronous active-low reset; no clearing pass.
//  A two-entry output buffer keeps input flowing while a result stalls;
//  o_in_ready drops only when both entries are full.
// ----------------------------------------------------------------------------
module framed_packet_receiver
    import fpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_command,
    output logic [15:0] o_error_field,
    output logic [15:0] o_payload_length,
    output logic [1:0]  o_status,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_data;
    logic    space;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_timeout_ms  <= GAP_TIMEOUT_RESET;
            r_cfg.max_payload_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAP_TIMEOUT: r_cfg.gap_timeout_ms  <= i_cfg_wdata;
                CFG_MAX_LEN:     r_cfg.max_payload_len <= i_cfg_wdata;
                default:         r_cfg                 <= r_cfg;
            endcase
        end
    end

    fpr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fpr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_result_kind    = out_data.result_kind;
    assign o_payload_byte   = out_data.payload_byte;
    assign o_payload_index  = out_data.payload_index;
    assign o_frame_type     = out_data.frame_type;
    assign o_command        = out_data.command;
    assign o_error_field    = out_data.error_field;
    assign o_payload_length = out_data.payload_length;
    assign o_status         = out_data.status;

endmodule

// File: rtl/fpr_checker.sv
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks on the framed packet receiver's result channel.
// ----------------------------------------------------------------------------
module fpr_checker
    import fpr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [7:0]  o_payload_byte,
    input logic [15:0] o_payload_index,
    input logic [7:0]  o_frame_type,
    input logic [15:0] o_command,
    input logic [15:0] o_error_field,
    input logic [15:0] o_payload_length,
    input logic [1:0]  o_status
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_payload_byte) && $stable(o_payload_index)
            && $stable(o_status) && $stable(o_payload_length))
        else $error("result beat changed while stalled");

    // Payload beats carry no header or status
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_PAYLOAD |->
            o_frame_type == 8'd0 && o_command == 16'd0 && o_error_field == 16'd0
            && o_payload_length == 16'd0 && o_status == STATUS_OK)
        else $error("payload beat carries header fields");

    // Frame end beats carry a known status and no payload
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_END |->
            (o_status == STATUS_OK || o_status == STATUS_CSUM_ERR
                || o_status == STATUS_LEN_ERR)
            && o_payload_byte == 8'd0 && o_payload_index == 16'd0)
        else $error("frame end beat malformed");

    // A length error only reports a non-zero length
    a_len_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_END && o_status == STATUS_LEN_ERR
            |-> o_payload_length != 16'd0)
        else $error("length error with zero length");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_result_kind    (o_result_kind),
    .o_payload_byte   (o_payload_byte),
    .o_payload_index  (o_payload_index),
    .o_frame_type     (o_frame_type),
    .o_command        (o_command),
    .o_error_field    (o_error_field),
    .o_payload_length (o_payload_length),
    .o_status         (o_status)
);

// File: bench/framed_packet_receiver_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_checker
// Watches the input, result and register ports of the frame receiver. It
// tracks the parser state beat by beat and queues the payload bytes and frame
// ends that each accepted beat should produce. Every accepted result is
// compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module framed_packet_receiver_checker
    import fpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_result_kind,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_payload_index,
    input  logic [7:0]  i_frame_type,
    input  logic [15:0] i_command,
    input  logic [15:0] i_error_field,
    input  logic [15:0] i_payload_length,
    input  logic [1:0]  i_status,
    // register writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // totals for the test top
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked
);

    // Register copies
    logic [15:0] gap_limit;
    logic [15:0] len_limit;

    // Parser copy
    t_phase      rx_phase;
    logic [7:0]  sum_q;
    logic [7:0]  type_q;
    logic [15:0] cmd_q;
    logic [15:0] err_q;
    logic [15:0] len_q;
    logic [15:0] data_count;
    logic [15:0] idle_ms;

    // Results the receiver still owes, oldest first
    t_result     results_due[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Build a frame-end result from the captured header
    function automatic t_result frame_end(input logic [1:0] st);
        t_result r;
        r                = '0;
        r.result_kind    = KIND_END;
        r.frame_type     = type_q;
        r.command        = cmd_q;
        r.error_field    = err_q;
        r.payload_length = len_q;
        r.status         = st;
        return r;
    endfunction

    // Advance the parser by one beat and queue whatever it emits
    task automatic track_rx_beat(input logic func, input logic [7:0] b);
        t_result r;
        if (func == FUNC_TICK) begin
            if (idle_ms != 16'hFFFF) idle_ms = idle_ms + 16'd1;
        end else begin
            // a long enough silence drops any frame in progress
            if (idle_ms >= gap_limit) rx_phase = PH_STX0;
            idle_ms = '0;
            case (rx_phase)
                PH_STX1: begin
                    if (b == START_BYTE_1) begin
                        sum_q    = sum_q + b;
                        rx_phase = PH_TYPE;
                    end else begin
                        rx_phase = PH_STX0;
                    end
                end
                PH_TYPE: begin
                    type_q   = b;
                    sum_q    = sum_q + b;
                    rx_phase = PH_CMD_L;
                end
                PH_CMD_L: begin
                    cmd_q    = {8'h00, b};
                    sum_q    = sum_q + b;
                    rx_phase = PH_CMD_H;
                end
                PH_CMD_H: begin
                    cmd_q[15:8] = b;
                    sum_q       = sum_q + b;
                    rx_phase    = PH_ERR_L;
                end
                PH_ERR_L: begin
                    err_q    = {8'h00, b};
                    sum_q    = sum_q + b;
                    rx_phase = PH_ERR_H;
                end
                PH_ERR_H: begin
                    err_q[15:8] = b;
                    sum_q       = sum_q + b;
                    rx_phase    = PH_LEN_L;
                end
                PH_LEN_L: begin
                    len_q    = {8'h00, b};
                    sum_q    = sum_q + b;
                    rx_phase = PH_LEN_H;
                end
                PH_LEN_H: begin
                    len_q[15:8] = b;
                    sum_q       = sum_q + b;
                    if (len_q == '0) begin
                        rx_phase = PH_CSUM;
                    end else if (len_q > len_limit) begin
                        rx_phase = PH_STX0;
                        results_due.push_back(frame_end(STATUS_LEN_ERR));
                    end else begin
                        data_count = '0;
                        rx_phase   = PH_DATA;
                    end
                end
                PH_DATA: begin
                    r               = '0;
                    r.result_kind   = KIND_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = data_count;
                    results_due.push_back(r);
                    sum_q      = sum_q + b;
                    data_count = data_count + 16'd1;
                    if (data_count == len_q) rx_phase = PH_CSUM;
                end
                PH_CSUM: begin
                    rx_phase = PH_STX0;
                    if (b == 8'd0 - sum_q) results_due.push_back(frame_end(STATUS_OK));
                    else results_due.push_back(frame_end(STATUS_CSUM_ERR));
                end
                default: begin
                    // hunting for the first start byte
                    if (b == START_BYTE_0) begin
                        sum_q    = b;
                        rx_phase = PH_STX1;
                    end else begin
                        rx_phase = PH_STX0;
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            o_mismatches = o_mismatches + 1;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Track registers and beats, compare results
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            gap_limit  = GAP_TIMEOUT_RESET;
            len_limit  = MAX_LEN_RESET;
            rx_phase   = PH_STX0;
            sum_q      = '0;
            type_q     = '0;
            cmd_q      = '0;
            err_q      = '0;
            len_q      = '0;
            data_count = '0;
            idle_ms    = '0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_GAP_TIMEOUT) gap_limit = i_cfg_wdata;
                else len_limit = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) track_rx_beat(i_func, i_rx_byte);
            if (i_out_valid && i_out_ready) begin
                o_checked = o_checked + 1;
                if (results_due.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    $display("%0t ns: unexpected result, expected none, actual kind %0d",
                             $time, i_result_kind, " byte 0x%0h status %0d",
                             i_payload_byte, i_status);
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", 16'(want.result_kind),
                                16'(i_result_kind));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(i_payload_byte));
                    check_field("payload_index", want.payload_index, i_payload_index);
                    check_field("frame_type", 16'(want.frame_type), 16'(i_frame_type));
                    check_field("command", want.command, i_command);
                    check_field("error_field", want.error_field, i_error_field);
                    check_field("payload_length", want.payload_length, i_payload_length);
                    check_field("status", 16'(want.status), 16'(i_status));
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

// File: bench/framed_packet_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_test
// Drives the frame receiver with a directed opening (start byte errors, zero
// length, oversize length, gap resync) and then random phases of well-formed,
// corrupted, cut-off and noise traffic mixed with millisecond ticks, under
// several register settings. A side checker predicts and compares results.
// ----------------------------------------------------------------------------
module framed_packet_receiver_test;
    import fpr_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 6;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int WHOLE_FRAME  = 1 << 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_func;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_result_kind;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_payload_index;
    logic [7:0]  o_frame_type;
    logic [15:0] o_command;
    logic [15:0] o_error_field;
    logic [15:0] o_payload_length;
    logic [1:0]  o_status;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [15:0] i_cfg_wdata;

    int          mismatches;
    int          pending;
    int          checked;

    // Stimulus bookkeeping
    int          items_sent;
    int          burst_left;
    int          settings_used;
    int          cycle_count;
    int          rx_cycle;
    bit          gaps_on;
    bit          tick_noise;
    bit          hold_off_req;
    bit          hold_off_done;
    logic [15:0] cur_gap;
    logic [15:0] cur_max;

    framed_packet_receiver u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_frame_type     (o_frame_type),
        .o_command        (o_command),
        .o_error_field    (o_error_field),
        .o_payload_length (o_payload_length),
        .o_status         (o_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    framed_packet_receiver_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_rx_byte        (i_rx_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_result_kind    (o_result_kind),
        .i_payload_byte   (o_payload_byte),
        .i_payload_index  (o_payload_index),
        .i_frame_type     (o_frame_type),
        .i_command        (o_command),
        .i_error_field    (o_error_field),
        .i_payload_length (o_payload_length),
        .i_status         (o_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("[framed_packet_receiver] ERROR");
        $finish;
    end

    // Result side: stall on a rotating pattern, one long hold-off on request
    initial begin
        i_out_ready   = 1'b0;
        hold_off_done = 1'b0;
        rx_cycle      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                rx_cycle = rx_cycle + 1;
                case ((rx_cycle / 256) % 4)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 99) < 70);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ((rx_cycle % 7) < 4);
                endcase
            end
        end
    end

    // Offer one beat and hold it until accepted; bursts and gaps are decided here
    task automatic send_beat(input logic func, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gaps_on ? $urandom_range(0, 6) : 0;
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent = items_sent + 1;
    endtask

    // Drop valid and wait until every owed result is out and the parser is quiet
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Write both registers on back-to-back cycles
    task automatic write_config(input logic [15:0] gap, input logic [15:0] max_len);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_GAP_TIMEOUT;
        i_cfg_wdata <= gap;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_MAX_LEN;
        i_cfg_wdata <= max_len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_gap       = gap;
        cur_max       = max_len;
        settings_used = settings_used + 1;
    endtask

    // Send a frame, or its first keep bytes; payload and checksum only when in range
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] cmd,
                              input logic [15:0] err, input logic [15:0] len,
                              input bit good_sum, input int keep);
        logic [7:0] frame_q[$];
        logic [7:0] sum;
        int         i;
        frame_q = {START_BYTE_0, START_BYTE_1, ftype, cmd[7:0], cmd[15:8],
                   err[7:0], err[15:8], len[7:0], len[15:8]};
        if (len <= cur_max) begin
            for (i = 0; i < int'(len); i++) frame_q.push_back(8'($urandom));
            sum = '0;
            foreach (frame_q[k]) sum = sum + frame_q[k];
            sum = 8'd0 - sum;
            if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
            frame_q.push_back(sum);
        end
        for (i = 0; i < frame_q.size() && i < keep; i++) begin
            // stray ticks inside a frame, enough to trip short timeouts
            if (tick_noise && $urandom_range(0, 39) == 0)
                repeat ($urandom_range(1, 3)) send_beat(FUNC_TICK, 8'($urandom));
            send_beat(FUNC_BYTE, frame_q[i]);
        end
    endtask

    // Mostly short in-range lengths, with zero, the limit and oversize mixed in
    function automatic logic [15:0] pick_length();
        int r;
        int hi;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        // no length is oversize when the limit is the largest value
        if ((r < 24 && cur_max != 16'hFFFF) || cur_max == '0) begin
            if ($urandom_range(0, 3) == 0) return 16'hFFFF;
            hi = int'(cur_max) + 40;
            if (hi > 65535) hi = 65535;
            return 16'($urandom_range(int'(cur_max) + 1, hi));
        end
        if (r < 30 && cur_max <= 16'd40) return cur_max;
        hi = (cur_max > 16'd12) ? 12 : int'(cur_max);
        return 16'($urandom_range(1, hi));
    endfunction

    // One random stretch of traffic
    task automatic random_segment();
        int          r;
        int          n;
        logic [15:0] len;
        r   = $urandom_range(0, 99);
        len = pick_length();
        if (r < 65) begin
            send_frame(8'($urandom), 16'($urandom), 16'($urandom), len,
                       $urandom_range(0, 5) != 0, WHOLE_FRAME);
        end else if (r < 75) begin
            // cut short somewhere before the checksum
            n = 9 + ((len <= cur_max) ? int'(len) : 0);
            send_frame(8'($urandom), 16'($urandom), 16'($urandom), len, 1'b1,
                       $urandom_range(1, n));
        end else if (r < 85) begin
            repeat ($urandom_range(1, 4))
                send_beat(FUNC_BYTE, $urandom_range(0, 1) ? START_BYTE_0 : 8'($urandom));
        end else begin
            // idle ticks, near the timeout when it is short
            n = $urandom_range(1, 4);
            if (cur_gap <= 16'd24 && $urandom_range(0, 1) == 1)
                n = int'(cur_gap) + $urandom_range(0, 2) - 1;
            if (n < 1) n = 1;
            repeat (n) send_beat(FUNC_TICK, 8'($urandom));
        end
    endtask

    task automatic run_phase(input logic [15:0] gap, input logic [15:0] max_len,
                             input int budget);
        int start;
        wait_idle();
        write_config(gap, max_len);
        start = items_sent;
        while (items_sent - start < budget) random_segment();
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_func        = FUNC_BYTE;
        i_rx_byte     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_GAP_TIMEOUT;
        i_cfg_wdata   = '0;
        items_sent    = 0;
        burst_left    = 0;
        settings_used = 1;
        gaps_on       = 1'b1;
        tick_noise    = 1'b1;
        hold_off_req  = 1'b0;
        cur_gap       = GAP_TIMEOUT_RESET;
        cur_max       = MAX_LEN_RESET;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a repeated first start byte, then a lone second start byte
        send_beat(FUNC_BYTE, START_BYTE_0);
        send_beat(FUNC_BYTE, START_BYTE_0);
        send_beat(FUNC_BYTE, START_BYTE_1);
        // zero length with a bad checksum, all-ones header
        tick_noise = 1'b0;
        send_frame(8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, WHOLE_FRAME);
        // largest length, far over the limit, all-zeros header
        send_frame(8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, WHOLE_FRAME);
        send_beat(FUNC_TICK, 8'hFF);
        // one tick with a timeout of one breaks the start pair
        wait_idle();
        write_config(16'd1, 16'd1);
        send_beat(FUNC_BYTE, START_BYTE_0);
        send_beat(FUNC_TICK, 8'h00);
        send_beat(FUNC_BYTE, START_BYTE_1);
        tick_noise = 1'b1;

        // Random phases across the register range
        run_phase(16'd1, 16'd1, 150);
        run_phase(16'hFFFF, 16'hFFFF, 250);
        run_phase(GAP_TIMEOUT_RESET, MAX_LEN_RESET, 250);
        run_phase(16'($urandom_range(2, 12)), 16'($urandom_range(1, 24)), 250);
        run_phase(16'd3, 16'd0, 100);
        run_phase(16'd0, 16'd20, 60);

        // Back-pressure: long frames at full rate while the result side holds off
        wait_idle();
        write_config(16'hFFFF, 16'd200);
        gaps_on      = 1'b0;
        tick_noise   = 1'b0;
        hold_off_req = 1'b1;
        repeat (3)
            send_frame(8'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom_range(110, 140)), 1'b1, WHOLE_FRAME);
        gaps_on    = 1'b1;
        tick_noise = 1'b1;

        run_phase(16'($urandom_range(4, 30)), 16'($urandom_range(8, 40)), 65);

        // Drain
        wait_idle();
        repeat (4 * SETTLE) @(negedge i_clk);

        $display("Run covered %0d input beats under %0d register settings,",
                 items_sent, settings_used);
        $display("with %0d results checked and %0d mismatches.", checked, mismatches);
        if (mismatches == 0) begin
            $display("[framed_packet_receiver] OK");
        end else begin
            $display("[framed_packet_receiver] ERROR");
        end
        $finish;
    end

endmodule
